// ----- rtl/core/symbol_frequency_table_sort_defines.svh -----
// Assertion macros used by the checker file.
`ifndef SYMBOL_FREQUENCY_TABLE_SORT_DEFINES_SVH
`define SYMBOL_FREQUENCY_TABLE_SORT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfts assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfts assertion failed");

`endif

// ----- rtl/core/sfts_pkg.sv -----
package sfts_pkg;

  localparam logic [1:0] OP_COUNT = 2'd0;
  localparam logic [1:0] OP_SORT  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam int IN_DATA_BITS  = 8;
  localparam int IN_USER_BITS  = 2;
  localparam int OUT_DATA_BITS = 48;
  localparam int SYM_BITS      = 8;
  localparam int OUT_CNT_BITS  = 32;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_COUNT,
    CMD_SWAP,
    CMD_ROTATE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      valid;
    logic      right_valid;
    logic      append;
    logic      pair_left;
  } cell_ctl_t;

endpackage

// ----- rtl/core/sfts_cell.sv -----
module sfts_cell import sfts_pkg::*; #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [SYM_BITS-1:0]   sym_in,
  input  logic [SYM_BITS-1:0]   left_sym,
  input  logic [COUNT_BITS-1:0] left_cnt,
  input  logic                  left_swap,
  input  logic [SYM_BITS-1:0]   right_sym,
  input  logic [COUNT_BITS-1:0] right_cnt,
  output logic                  match,
  output logic                  swap_right,
  output logic [SYM_BITS-1:0]   sym_o,
  output logic [COUNT_BITS-1:0] cnt_o
);

  logic [SYM_BITS-1:0]   sym_r, sym_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  assign match      = ctl.valid && (sym_r == sym_in);
  assign swap_right = (ctl.cmd == CMD_SWAP) && ctl.pair_left && ctl.right_valid &&
                      (cnt_r > right_cnt);
  assign sym_o = sym_r;
  assign cnt_o = cnt_r;

  always_comb begin
    sym_nxt = sym_r;
    cnt_nxt = cnt_r;
    unique case (ctl.cmd)
      CMD_COUNT: begin
        if (match && (cnt_r != '1)) begin
          cnt_nxt = cnt_r + COUNT_BITS'(1);
        end
        if (ctl.append) begin
          sym_nxt = sym_in;
          cnt_nxt = COUNT_BITS'(1);
        end
      end
      CMD_SWAP: begin
        if (swap_right) begin
          sym_nxt = right_sym;
          cnt_nxt = right_cnt;
        end else if (left_swap) begin
          sym_nxt = left_sym;
          cnt_nxt = left_cnt;
        end
      end
      CMD_ROTATE: begin
        sym_nxt = right_sym;
        cnt_nxt = right_cnt;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sym_r <= sym_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

// ----- rtl/core/symbol_frequency_table_sort.sv -----
// Count and clear beats may arrive in every cycle while no sort is in progress.
// A sort beat runs odd-even exchange steps across the cell row in ST_SORT, then
// rotation steps in ST_READ that emit the used entries one per cycle while the output is free.
// Synchronous active-low reset empties the table and clears the dropped flag;
// the cell contents themselves are not reset.
module symbol_frequency_table_sort import sfts_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int COUNT_BITS    = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // [7:0] symbol
  input  logic [IN_USER_BITS-1:0]  in_tuser,   // [1:0] operation
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // [7:0] symbol, [39:8] count, [40] dropped
  output logic                     out_tlast
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_READ
  } state_t;

  state_t                state_r;
  logic [CW-1:0]         used_r;
  logic [CW-1:0]         step_r;
  logic                  ovf_r;
  logic                  out_valid_r;
  logic [SYM_BITS-1:0]   out_sym_r;
  logic [OUT_CNT_BITS-1:0] out_cnt_r;
  logic                  out_last_r;
  logic                  out_drop_r;

  logic                  accept;
  logic                  rot_go;
  logic                  hit;
  logic                  full;
  cell_cmd_t             cmd;

  logic [TABLE_ENTRIES-1:0] match;
  logic [TABLE_ENTRIES-1:0] swap_r;
  logic [SYM_BITS-1:0]      cell_sym [TABLE_ENTRIES];
  logic [COUNT_BITS-1:0]    cell_cnt [TABLE_ENTRIES];
  cell_ctl_t                ctl      [TABLE_ENTRIES];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign rot_go    = (state_r == ST_READ) && (!out_valid_r || out_tready);
  assign hit       = |match;
  assign full      = (used_r == CW'(TABLE_ENTRIES));

  always_comb begin
    if (accept && (in_tuser == OP_COUNT)) begin
      cmd = CMD_COUNT;
    end else if (state_r == ST_SORT) begin
      cmd = CMD_SWAP;
    end else if (rot_go) begin
      cmd = CMD_ROTATE;
    end else begin
      cmd = CMD_HOLD;
    end
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    localparam int L = (i == 0) ? TABLE_ENTRIES - 1 : i - 1;
    localparam int R = (i == TABLE_ENTRIES - 1) ? 0 : i + 1;

    always_comb begin
      ctl[i].cmd         = cmd;
      ctl[i].valid       = (used_r > CW'(i));
      ctl[i].right_valid = (i < TABLE_ENTRIES - 1) && (used_r > CW'(R));
      ctl[i].append      = (used_r == CW'(i)) && !hit;
      ctl[i].pair_left   = (i < TABLE_ENTRIES - 1) && (1'(i) == step_r[0]);
    end

    sfts_cell #(
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .sym_in    (in_tdata[SYM_BITS-1:0]),
      .left_sym  (cell_sym[L]),
      .left_cnt  (cell_cnt[L]),
      .left_swap ((i == 0) ? 1'b0 : swap_r[L]),
      .right_sym (cell_sym[R]),
      .right_cnt (cell_cnt[R]),
      .match     (match[i]),
      .swap_right(swap_r[i]),
      .sym_o     (cell_sym[i]),
      .cnt_o     (cell_cnt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      step_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
          end
          if (accept) begin
            case (in_tuser)
              OP_COUNT: begin
                if (!hit) begin
                  if (full) begin
                    ovf_r <= 1'b1;
                  end else begin
                    used_r <= used_r + CW'(1);
                  end
                end
              end
              OP_SORT: begin
                if (used_r != '0) begin
                  state_r <= ST_SORT;
                  step_r  <= '0;
                end
              end
              OP_CLEAR: begin
                used_r <= '0;
                ovf_r  <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SORT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
          end
          if (step_r == CW'(TABLE_ENTRIES - 1)) begin
            state_r <= ST_READ;
            step_r  <= '0;
          end else begin
            step_r <= step_r + CW'(1);
          end
        end
        ST_READ: begin
          if (rot_go) begin
            if (step_r < used_r) begin
              out_valid_r <= 1'b1;
              out_sym_r   <= cell_sym[0];
              out_cnt_r   <= OUT_CNT_BITS'(cell_cnt[0]);
              out_last_r  <= (step_r == used_r - CW'(1));
              out_drop_r  <= ovf_r;
            end else begin
              out_valid_r <= 1'b0;
            end
            if (step_r == CW'(TABLE_ENTRIES - 1)) begin
              state_r <= ST_IDLE;
              step_r  <= '0;
            end else begin
              step_r <= step_r + CW'(1);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_drop_r, out_cnt_r, out_sym_r};

endmodule

// ----- rtl/core/sfts_checker.sv -----
`include "symbol_frequency_table_sort_defines.svh"

module sfts_checker import sfts_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tvalid,
  input logic                     in_tready,
  input logic [IN_USER_BITS-1:0]  in_tuser,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata,
  input logic                     out_tlast
);

  // A stalled result beat keeps its payload.
  `SFTS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Count, clear and unknown beats never stall the input side.
  `SFTS_ASSERT_NXT(a_fast_ops, in_tvalid && in_tready && (in_tuser != OP_SORT), in_tready)

  // A readout run delivers its beats without gaps once the sink takes them.
  `SFTS_ASSERT_NXT(a_run_dense, out_tvalid && out_tready && !out_tlast, out_tvalid)

  // No new item is taken while a readout run is still in progress.
  `SFTS_ASSERT_IMP(a_busy_run, out_tvalid && !out_tlast, !in_tready)

endmodule

bind symbol_frequency_table_sort sfts_checker u_sfts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

import sfts_pkg::*;

typedef struct packed {
  logic [SYM_BITS-1:0]     sym;
  logic [OUT_CNT_BITS-1:0] cnt;
  logic                    last;
  logic                    dropped;
} freq_entry_t;

class freq_table_board;
  localparam int DEPTH = 64;

  logic [SYM_BITS-1:0]     sym_tab[DEPTH];
  logic [OUT_CNT_BITS-1:0] cnt_tab[DEPTH];
  int unsigned             used;
  bit                      overflow;
  freq_entry_t             sorted_entries_due[$];
  int unsigned             beats;
  int unsigned             readouts;
  int unsigned             full_readouts;
  int unsigned             checked;
  int unsigned             errors;

  function void note_beat(logic [1:0] op, logic [SYM_BITS-1:0] sym);
    logic [SYM_BITS-1:0]     s;
    logic [OUT_CNT_BITS-1:0] c;
    int                      j;
    bit                      hit;
    freq_entry_t             e;
    if (op == OP_COUNT) begin
      hit = 1'b0;
      for (int i = 0; i < used; i++) begin
        if (!hit && sym_tab[i] == sym) begin
          hit = 1'b1;
          if (cnt_tab[i] != '1) cnt_tab[i] = cnt_tab[i] + OUT_CNT_BITS'(1);
        end
      end
      if (!hit) begin
        if (used < DEPTH) begin
          sym_tab[used] = sym;
          cnt_tab[used] = OUT_CNT_BITS'(1);
          used++;
        end else begin
          overflow = 1'b1;
        end
      end
    end else if (op == OP_SORT) begin
      // An entry moves left only past strictly larger counts, so ties keep their order.
      for (int i = 1; i < used; i++) begin
        s = sym_tab[i];
        c = cnt_tab[i];
        j = i;
        while (j > 0 && cnt_tab[j-1] > c) begin
          sym_tab[j] = sym_tab[j-1];
          cnt_tab[j] = cnt_tab[j-1];
          j--;
        end
        sym_tab[j] = s;
        cnt_tab[j] = c;
      end
      for (int k = 0; k < used; k++) begin
        e.sym     = sym_tab[k];
        e.cnt     = cnt_tab[k];
        e.last    = (k + 1 == used);
        e.dropped = overflow;
        sorted_entries_due.push_back(e);
      end
      readouts++;
      if (overflow) full_readouts++;
    end else if (op == OP_CLEAR) begin
      used     = 0;
      overflow = 1'b0;
    end
    beats++;
  endfunction

  function void check_entry(logic [OUT_DATA_BITS-1:0] data, logic last);
    freq_entry_t e;
    if (sorted_entries_due.size() == 0) begin
      $error("Output beat with no table entry pending: data %0h, last %0b", data, last);
      errors++;
      return;
    end
    e = sorted_entries_due.pop_front();
    checked++;
    if (data[7:0] !== e.sym) begin
      $error("entry_symbol mismatch: expected %0h, actual %0h", e.sym, data[7:0]);
      errors++;
    end
    if (data[39:8] !== e.cnt) begin
      $error("entry_count mismatch: expected %0d, actual %0d", e.cnt, data[39:8]);
      errors++;
    end
    if (last !== e.last) begin
      $error("last_entry mismatch: expected %0b, actual %0b", e.last, last);
      errors++;
    end
    if (data[40] !== e.dropped) begin
      $error("dropped_flag mismatch: expected %0b, actual %0b", e.dropped, data[40]);
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int unsigned ITEMS = 360;
  localparam int unsigned QUIET_FROM = 300;
  localparam int unsigned LIMIT = 1000000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic [IN_USER_BITS-1:0]  in_tuser = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     out_tlast;

  freq_table_board sb = new();
  bit              idle_in = 1'b0;
  bit              idle_out = 1'b0;
  int unsigned     stall_left = 0;
  int unsigned     cycles = 0;

  symbol_frequency_table_sort u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("symbol_frequency_table_sort verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_entry(out_tdata, out_tlast);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= (stall_left == 0);
    end else if (idle_out && sb.beats < QUIET_FROM && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_beat(input logic [1:0] op, input logic [7:0] sym);
    if (idle_in && sb.beats < QUIET_FROM && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= sym;
    do @(posedge clk); while (!in_tready);
    sb.note_beat(op, sym);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.sorted_entries_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_frame(input bit fill_past_end);
    int unsigned pool;
    int unsigned n;
    logic [7:0]  base;
    logic [7:0]  s;
    if ($urandom_range(0, 9) < 8) push_beat(OP_CLEAR, 8'($urandom));
    if (fill_past_end) begin
      pool = $urandom_range(65, 80);
      n    = pool + $urandom_range(0, 20);
    end else begin
      pool = $urandom_range(1, 24);
      n    = $urandom_range(1, 40);
    end
    base = 8'($urandom);
    for (int k = 0; k < n; k++) begin
      if (fill_past_end && k < pool) s = base + 8'(k);
      else s = base + 8'($urandom_range(0, pool - 1));
      if ($urandom_range(0, 19) == 0) push_beat(2'($urandom_range(0, 3)), 8'($urandom));
      push_beat(OP_COUNT, s);
    end
    if ($urandom_range(0, 9) != 0) push_beat(OP_SORT, 8'($urandom));
  endtask

  initial begin
    int unsigned frames;
    frames = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_beat(OP_SORT, 8'h00);
    push_beat(OP_NONE, 8'hFF);
    push_beat(OP_COUNT, 8'h00);
    push_beat(OP_COUNT, 8'hFF);
    push_beat(OP_COUNT, 8'hAA);
    push_beat(OP_COUNT, 8'h55);
    push_beat(OP_COUNT, 8'hFF);
    push_beat(OP_COUNT, 8'h00);
    push_beat(OP_COUNT, 8'hFF);
    push_beat(OP_SORT, 8'hFF);
    push_beat(OP_COUNT, 8'h55);
    push_beat(OP_COUNT, 8'h55);
    push_beat(OP_COUNT, 8'h01);
    push_beat(OP_SORT, 8'h80);
    push_beat(OP_CLEAR, 8'hFF);
    push_beat(OP_SORT, 8'h7F);
    push_beat(OP_COUNT, 8'h7E);
    push_beat(OP_SORT, 8'h01);
    push_beat(OP_NONE, 8'h00);
    wait_drained();

    while (sb.beats < ITEMS) begin
      idle_in  = (sb.beats < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      idle_out = (sb.beats < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      run_frame(frames == 0 || $urandom_range(0, 7) == 0);
      if (frames == 1 || $urandom_range(0, 3) == 0) wait_drained();
      frames++;
    end
    idle_in  = 1'b0;
    idle_out = 1'b0;
    wait_drained();
    repeat (200) @(posedge clk);

    $display("Run covered %0d beats and %0d readouts (%0d after overflow); %0d entries checked.",
             sb.beats, sb.readouts, sb.full_readouts, sb.checked);
    if (sb.errors == 0 && sb.sorted_entries_due.size() == 0) begin
      $display("symbol_frequency_table_sort verification clean");
    end else begin
      $display("symbol_frequency_table_sort verification failed");
    end
    $finish;
  end
endmodule
